// ----- src/dpw_pkg.sv -----
// Shared types, register codes, reset values and the divide-by-125 helper
// for the depth pixel back-projection pipeline. No dependencies.
package dpw_pkg;

  // camera-space widths
  localparam int CAM_W  = 36;   // signed Q20.16 camera x/y
  localparam int CAMZ_W = 23;   // unsigned Q7.16 camera z

  localparam logic [47:0] ROT_ROW0_RST  = 48'h4000_0000_0000;
  localparam logic [47:0] ROT_ROW1_RST  = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_ROW2_RST  = 48'h0000_0000_4000;
  localparam logic [31:0] PRINC_PT_RST  = 32'h1458_0FD8;       // cx 325.5, cy 253.5
  localparam logic [47:0] FOCAL_RCP_RST = 48'h007E84_007E46;   // 1/518, 1/519

  // (x * ceil(2^36/125)) >> 36 equals floor(x/125) for x < 2^32
  localparam logic [29:0] DIV125_MUL = 30'd549755814;
  localparam logic [58:0] XY_ROUND_BIAS = 59'd2048000;         // half of 4096000
  localparam logic [31:0] Z_ROUND_BIAS = 32'd500;

  typedef enum logic [2:0] {
    REG_ROT_ROW0,
    REG_ROT_ROW1,
    REG_ROT_ROW2,
    REG_TRANS_X,
    REG_TRANS_Y,
    REG_TRANS_Z,
    REG_PRINC_PT,
    REG_FOCAL_RCP
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [15:0] depth_raw;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [7:0]         blue_out;
    logic [7:0]         green_out;
    logic [7:0]         red_out;
  } out_item_t;

  typedef struct packed {
    logic [47:0]        rot_row0;
    logic [47:0]        rot_row1;
    logic [47:0]        rot_row2;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [23:0]        rfx;
    logic [23:0]        rfy;
  } cfg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  typedef struct packed {
    logic signed [CAM_W-1:0] cam_x;
    logic signed [CAM_W-1:0] cam_y;
    logic [CAMZ_W-1:0]       cam_z;
    color_t                  color;
  } cam_point_t;

  // floor(n / 125) for n < 2^29
  function automatic logic [22:0] div125(input logic [28:0] n);
    logic [58:0] p;
    p = 59'(n) * 59'(DIV125_MUL);
    return p[58:36];
  endfunction

endpackage

// ----- src/dpw_cfg_regs.sv -----
// Configuration register file for the back-projection pipeline.
// Depends on dpw_pkg (register codes, reset values, cfg_t).
module dpw_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [47:0]       cfg_data,
  output dpw_pkg::cfg_t     cfg
);

  logic [47:0] rot0_r, rot0_nxt;
  logic [47:0] rot1_r, rot1_nxt;
  logic [47:0] rot2_r, rot2_nxt;
  logic [31:0] tx_r, tx_nxt;
  logic [31:0] ty_r, ty_nxt;
  logic [31:0] tz_r, tz_nxt;
  logic [31:0] pp_r, pp_nxt;
  logic [47:0] fr_r, fr_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    rot0_nxt = rot0_r;
    rot1_nxt = rot1_r;
    rot2_nxt = rot2_r;
    tx_nxt   = tx_r;
    ty_nxt   = ty_r;
    tz_nxt   = tz_r;
    pp_nxt   = pp_r;
    fr_nxt   = fr_r;
    if (cfg_valid && cfg_ready) begin
      unique case (dpw_pkg::cfg_reg_e'(cfg_index))
        dpw_pkg::REG_ROT_ROW0:  rot0_nxt = cfg_data;
        dpw_pkg::REG_ROT_ROW1:  rot1_nxt = cfg_data;
        dpw_pkg::REG_ROT_ROW2:  rot2_nxt = cfg_data;
        dpw_pkg::REG_TRANS_X:   tx_nxt   = cfg_data[31:0];
        dpw_pkg::REG_TRANS_Y:   ty_nxt   = cfg_data[31:0];
        dpw_pkg::REG_TRANS_Z:   tz_nxt   = cfg_data[31:0];
        dpw_pkg::REG_PRINC_PT:  pp_nxt   = cfg_data[31:0];
        dpw_pkg::REG_FOCAL_RCP: fr_nxt   = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot0_r <= dpw_pkg::ROT_ROW0_RST;
      rot1_r <= dpw_pkg::ROT_ROW1_RST;
      rot2_r <= dpw_pkg::ROT_ROW2_RST;
      tx_r   <= '0;
      ty_r   <= '0;
      tz_r   <= '0;
      pp_r   <= dpw_pkg::PRINC_PT_RST;
      fr_r   <= dpw_pkg::FOCAL_RCP_RST;
    end else begin
      rot0_r <= rot0_nxt;
      rot1_r <= rot1_nxt;
      rot2_r <= rot2_nxt;
      tx_r   <= tx_nxt;
      ty_r   <= ty_nxt;
      tz_r   <= tz_nxt;
      pp_r   <= pp_nxt;
      fr_r   <= fr_nxt;
    end
  end

  always_comb begin
    cfg.rot_row0 = rot0_r;
    cfg.rot_row1 = rot1_r;
    cfg.rot_row2 = rot2_r;
    cfg.trans_x  = $signed(tx_r);
    cfg.trans_y  = $signed(ty_r);
    cfg.trans_z  = $signed(tz_r);
    cfg.cx       = pp_r[31:16];
    cfg.cy       = pp_r[15:0];
    cfg.rfx      = fr_r[47:24];
    cfg.rfy      = fr_r[23:0];
  end

endmodule

// ----- src/dpw_cam.sv -----
// Six-stage camera back-projection: pixel offset, depth and focal products,
// rounded exact divide by 4096000 as two chunks of divide-by-125, camera z.
// Depends on dpw_pkg (cfg_t, in_item_t, cam_point_t, div125).
module dpw_cam (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  dpw_pkg::in_item_t     in_data,
  input  dpw_pkg::cfg_t         cfg,
  output logic                  cam_valid,
  output dpw_pkg::cam_point_t   cam_pt
);

  // lane 0 is x, lane 1 is y

  // stage 1: pixel offset in Q.4
  logic               v1_r, v1_nxt;
  logic signed [16:0] du1_r [2];
  logic signed [16:0] du1_nxt [2];
  logic [15:0]        d1_r, d1_nxt;
  dpw_pkg::color_t    c1_r, c1_nxt;

  // stage 2: offset * depth, z numerator
  logic               v2_r;
  logic signed [33:0] px2_r [2];
  logic signed [33:0] px2_nxt [2];
  logic [28:0]        nz2_r, nz2_nxt;
  logic [31:0]        zsum2;
  dpw_pkg::color_t    c2_r;

  // stage 3: * focal reciprocal, z quotient
  logic               v3_r;
  logic signed [58:0] pr3_r [2];
  logic signed [58:0] pr3_nxt [2];
  logic [22:0]        qz3_r, qz3_nxt;
  dpw_pkg::color_t    c3_r;

  // stage 4: magnitude + rounding bias, pre-shift by 2^15
  logic               v4_r;
  logic               s4_r [2];
  logic               s4_nxt [2];
  logic [40:0]        k4_r [2];
  logic [40:0]        k4_nxt [2];
  logic [58:0]        mag4 [2];
  logic [58:0]        nsum4 [2];
  logic [22:0]        qz4_r;
  dpw_pkg::color_t    c4_r;

  // stage 5: high chunk divide by 125, remainder joins low chunk
  logic               v5_r;
  logic               s5_r [2];
  logic [14:0]        qh5_r [2];
  logic [14:0]        qh5_nxt [2];
  logic [26:0]        low5_r [2];
  logic [26:0]        low5_nxt [2];
  logic [22:0]        qa5 [2];
  logic [21:0]        qm5 [2];
  logic [21:0]        rem5 [2];
  logic [22:0]        qz5_r;
  dpw_pkg::color_t    c5_r;

  // stage 6: low chunk divide, sign restore
  logic                              v6_r;
  dpw_pkg::cam_point_t               pt6_r, pt6_nxt;
  logic [22:0]                       qb6 [2];
  logic [dpw_pkg::CAM_W-1:0]         q6 [2];
  logic signed [dpw_pkg::CAM_W-1:0]  cam6 [2];

  always_comb begin
    v1_nxt       = in_valid && (in_data.depth_raw != 16'd0);
    d1_nxt       = in_data.depth_raw;
    c1_nxt.blue  = in_data.blue_in;
    c1_nxt.green = in_data.green_in;
    c1_nxt.red   = in_data.red_in;
    du1_nxt[0]   = $signed({1'b0, in_data.col, 4'd0}) - $signed({1'b0, cfg.cx});
    du1_nxt[1]   = $signed({1'b0, in_data.row, 4'd0}) - $signed({1'b0, cfg.cy});
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      px2_nxt[i] = du1_r[i] * $signed({1'b0, d1_r});
    end
    zsum2   = {d1_r, 16'd0} + dpw_pkg::Z_ROUND_BIAS;
    nz2_nxt = zsum2[31:3];
  end

  always_comb begin
    pr3_nxt[0] = px2_r[0] * $signed({1'b0, cfg.rfx});
    pr3_nxt[1] = px2_r[1] * $signed({1'b0, cfg.rfy});
    qz3_nxt    = dpw_pkg::div125(nz2_r);
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s4_nxt[i] = pr3_r[i][58];
      mag4[i]   = pr3_r[i][58] ? 59'(-pr3_r[i]) : 59'(pr3_r[i]);
      nsum4[i]  = mag4[i] + dpw_pkg::XY_ROUND_BIAS;
      k4_nxt[i] = nsum4[i][55:15];
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      qa5[i]      = dpw_pkg::div125({8'd0, k4_r[i][40:20]});
      qh5_nxt[i]  = qa5[i][14:0];
      qm5[i]      = {7'd0, qh5_nxt[i]} * 22'd125;
      rem5[i]     = {1'b0, k4_r[i][40:20]} - qm5[i];
      low5_nxt[i] = {rem5[i][6:0], k4_r[i][19:0]};
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      qb6[i]  = dpw_pkg::div125({2'd0, low5_r[i]});
      q6[i]   = {1'b0, qh5_r[i], qb6[i][19:0]};
      cam6[i] = s5_r[i] ? -$signed(q6[i]) : $signed(q6[i]);
    end
    pt6_nxt.cam_x = cam6[0];
    pt6_nxt.cam_y = cam6[1];
    pt6_nxt.cam_z = qz5_r;
    pt6_nxt.color = c5_r;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    d1_r  <= d1_nxt;
    c1_r  <= c1_nxt;
    nz2_r <= nz2_nxt;
    c2_r  <= c1_r;
    qz3_r <= qz3_nxt;
    c3_r  <= c2_r;
    qz4_r <= qz3_r;
    c4_r  <= c3_r;
    qz5_r <= qz4_r;
    c5_r  <= c4_r;
    pt6_r <= pt6_nxt;
    for (int i = 0; i < 2; i++) begin
      du1_r[i]  <= du1_nxt[i];
      px2_r[i]  <= px2_nxt[i];
      pr3_r[i]  <= pr3_nxt[i];
      s4_r[i]   <= s4_nxt[i];
      k4_r[i]   <= k4_nxt[i];
      s5_r[i]   <= s4_r[i];
      qh5_r[i]  <= qh5_nxt[i];
      low5_r[i] <= low5_nxt[i];
    end
  end

  assign cam_valid = v6_r;
  assign cam_pt    = pt6_r;

  a_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> d1_r != 16'd0)
    else $error("zero-depth pixel entered the pipeline");

  a_chunk_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (low5_r[0][26:20] < 7'd125) && (low5_r[1][26:20] < 7'd125))
    else $error("high-chunk remainder not below 125");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> ##5 v6_r)
    else $error("request lost in camera stages");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> ##5 !v6_r)
    else $error("camera stages produced a request from nothing");

endmodule

// ----- src/dpw_xform.sv -----
// Three-stage rigid transform: rotation products, sum with translation,
// round to Q16.16 and saturate into the output register.
// Depends on dpw_pkg (cfg_t, cam_point_t, out_item_t).
module dpw_xform (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cam_valid,
  input  dpw_pkg::cam_point_t   cam_pt,
  input  dpw_pkg::cfg_t         cfg,
  output logic                  out_valid,
  output dpw_pkg::out_item_t    out_data
);

  localparam logic signed [53:0] SAT_MAX = 54'sd2147483647;
  localparam logic signed [53:0] SAT_MIN = -54'sd2147483648;

  logic [47:0]                       rot [3];
  logic signed [31:0]                tr [3];
  logic signed [dpw_pkg::CAM_W-1:0]  camv [3];
  logic signed [15:0]                rent [3][3];

  // stage A: nine Q1.14 x Q20.16 products
  logic               va_r;
  logic signed [51:0] pa_r [3][3];
  logic signed [51:0] pa_nxt [3][3];
  dpw_pkg::color_t    ca_r;

  // stage B: row sums in Q.30
  logic               vb_r;
  logic signed [53:0] sb_r [3];
  logic signed [53:0] sb_nxt [3];
  dpw_pkg::color_t    cb_r;

  // stage C: round, saturate
  logic                 vc_r;
  dpw_pkg::out_item_t   oc_r, oc_nxt;
  logic signed [53:0]   bias [3];
  logic signed [53:0]   rs [3];
  logic signed [31:0]   wc [3];

  always_comb begin
    rot[0]  = cfg.rot_row0;
    rot[1]  = cfg.rot_row1;
    rot[2]  = cfg.rot_row2;
    tr[0]   = cfg.trans_x;
    tr[1]   = cfg.trans_y;
    tr[2]   = cfg.trans_z;
    camv[0] = cam_pt.cam_x;
    camv[1] = cam_pt.cam_y;
    camv[2] = $signed({{(dpw_pkg::CAM_W - dpw_pkg::CAMZ_W){1'b0}}, cam_pt.cam_z});
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rent[i][j]   = $signed(rot[i][47 - 16*j -: 16]);
        pa_nxt[i][j] = rent[i][j] * camv[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sb_nxt[i] = 54'(pa_r[i][0]) + 54'(pa_r[i][1]) + 54'(pa_r[i][2])
                + (54'(tr[i]) <<< 14);
    end
  end

  // ties away from zero: negative sums take one less bias
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bias[i] = sb_r[i][53] ? 54'sd8191 : 54'sd8192;
      rs[i]   = (sb_r[i] + bias[i]) >>> 14;
      if (rs[i] > SAT_MAX) begin
        wc[i] = 32'sh7FFF_FFFF;
      end else if (rs[i] < SAT_MIN) begin
        wc[i] = 32'sh8000_0000;
      end else begin
        wc[i] = rs[i][31:0];
      end
    end
    oc_nxt.world_x   = wc[0];
    oc_nxt.world_y   = wc[1];
    oc_nxt.world_z   = wc[2];
    oc_nxt.blue_out  = cb_r.blue;
    oc_nxt.green_out = cb_r.green;
    oc_nxt.red_out   = cb_r.red;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= cam_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    ca_r <= cam_pt.color;
    cb_r <= ca_r;
    oc_r <= oc_nxt;
    for (int i = 0; i < 3; i++) begin
      sb_r[i] <= sb_nxt[i];
      for (int j = 0; j < 3; j++) begin
        pa_r[i][j] <= pa_nxt[i][j];
      end
    end
  end

  assign out_valid = vc_r;
  assign out_data  = oc_r;

  a_xform_latency: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> ##2 out_valid)
    else $error("request lost in transform stages");

  a_xform_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    !va_r |-> ##2 !out_valid)
    else $error("transform stages produced a request from nothing");

endmodule

// ----- src/depth_pixel_to_world_point.sv -----
// Depth pixel to world point: each accepted pixel passes the dpw_cam and dpw_xform stages, then strobes out_valid.
// Throughput one pixel per cycle; busy stays low, a nine-register pipeline with no stalls.
// Zero-depth pixels are dropped and give no strobe. The receiver cannot stall.
// Synchronous active-low reset clears the pipeline valids and loads the register defaults.
// Depends on dpw_pkg, dpw_cfg_regs, dpw_cam, dpw_xform.
module depth_pixel_to_world_point (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dpw_pkg::in_item_t    in_data,
  output logic                 out_valid,
  output dpw_pkg::out_item_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [47:0]          cfg_data
);

  dpw_pkg::cfg_t        cfg;
  logic                 in_accept;
  logic                 cam_valid;
  dpw_pkg::cam_point_t  cam_pt;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  dpw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpw_cam u_cam (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_accept),
    .in_data   (in_data),
    .cfg       (cfg),
    .cam_valid (cam_valid),
    .cam_pt    (cam_pt)
  );

  dpw_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .cam_valid (cam_valid),
    .cam_pt    (cam_pt),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- tb/dpw_point_checker.sv -----
`timescale 1ns / 1ps
// Pixel-to-world checker: mirrors the register file, predicts each world point
// for accepted pixels and compares the strobed results in order. Depends on dpw_pkg.
module dpw_point_checker
  import dpw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  out_item_t  out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [47:0] cfg_data,
  output int         mismatch_count,
  output int         points_pending
);

  localparam longint MM_Q12_DIV = 64'd4096000;   // mm to m, Q.4 * Q0.24 down to Q.16

  cfg_t      regs;
  out_item_t expected_points[$];
  int        err_cnt;

  function automatic longint round_div_away(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // one row of R times the camera point, plus translation, back to saturated Q16.16
  function automatic logic signed [31:0] world_axis(input logic [47:0] r,
                                                    input logic signed [31:0] t,
                                                    input longint cx, input longint cy,
                                                    input longint cz);
    longint acc;
    acc = longint'($signed(r[47:32])) * cx + longint'($signed(r[31:16])) * cy
        + longint'($signed(r[15:0])) * cz + longint'(t) * 16384;
    acc = round_div_away(acc, 16384);
    if (acc > 64'sd2147483647) return 32'sh7fff_ffff;
    if (acc < -64'sd2147483648) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  function automatic out_item_t backproject_pixel(input in_item_t px, input cfg_t c);
    out_item_t p;
    longint    d;
    longint    du;
    longint    dv;
    longint    cam_x;
    longint    cam_y;
    longint    cam_z;
    d  = longint'(px.depth_raw);
    du = longint'(px.col) * 16 - longint'(c.cx);
    dv = longint'(px.row) * 16 - longint'(c.cy);
    cam_x = round_div_away(du * d * longint'(c.rfx), MM_Q12_DIV);
    cam_y = round_div_away(dv * d * longint'(c.rfy), MM_Q12_DIV);
    cam_z = (d * 65536 + 500) / 1000;
    p.world_x   = world_axis(c.rot_row0, c.trans_x, cam_x, cam_y, cam_z);
    p.world_y   = world_axis(c.rot_row1, c.trans_y, cam_x, cam_y, cam_z);
    p.world_z   = world_axis(c.rot_row2, c.trans_z, cam_x, cam_y, cam_z);
    p.blue_out  = px.blue_in;
    p.green_out = px.green_in;
    p.red_out   = px.red_in;
    return p;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v,
                             input logic has_x);
    if (has_x || exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      regs.rot_row0 = ROT_ROW0_RST;
      regs.rot_row1 = ROT_ROW1_RST;
      regs.rot_row2 = ROT_ROW2_RST;
      regs.trans_x  = '0;
      regs.trans_y  = '0;
      regs.trans_z  = '0;
      regs.cx       = PRINC_PT_RST[31:16];
      regs.cy       = PRINC_PT_RST[15:0];
      regs.rfx      = FOCAL_RCP_RST[47:24];
      regs.rfy      = FOCAL_RCP_RST[23:0];
      expected_points.delete();
      err_cnt = 0;
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result: world_x %0d world_y %0d world_z %0d",
                 out_data.world_x, out_data.world_y, out_data.world_z);
          err_cnt++;
        end else begin
          e = expected_points.pop_front();
          check_field("world_x", longint'(e.world_x), longint'(out_data.world_x),
                      $isunknown(out_data.world_x));
          check_field("world_y", longint'(e.world_y), longint'(out_data.world_y),
                      $isunknown(out_data.world_y));
          check_field("world_z", longint'(e.world_z), longint'(out_data.world_z),
                      $isunknown(out_data.world_z));
          check_field("blue_out", longint'(e.blue_out), longint'(out_data.blue_out),
                      $isunknown(out_data.blue_out));
          check_field("green_out", longint'(e.green_out), longint'(out_data.green_out),
                      $isunknown(out_data.green_out));
          check_field("red_out", longint'(e.red_out), longint'(out_data.red_out),
                      $isunknown(out_data.red_out));
        end
      end
      // zero depth is dropped by the block
      if (start && !busy && in_data.depth_raw != 16'd0)
        expected_points = {expected_points, backproject_pixel(in_data, regs)};
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_e'(cfg_index))
          REG_ROT_ROW0:  regs.rot_row0 = cfg_data;
          REG_ROT_ROW1:  regs.rot_row1 = cfg_data;
          REG_ROT_ROW2:  regs.rot_row2 = cfg_data;
          REG_TRANS_X:   regs.trans_x  = cfg_data[31:0];
          REG_TRANS_Y:   regs.trans_y  = cfg_data[31:0];
          REG_TRANS_Z:   regs.trans_z  = cfg_data[31:0];
          REG_PRINC_PT: begin
            regs.cx = cfg_data[31:16];
            regs.cy = cfg_data[15:0];
          end
          REG_FOCAL_RCP: begin
            regs.rfx = cfg_data[47:24];
            regs.rfy = cfg_data[23:0];
          end
          default: ;
        endcase
      end
    end
    mismatch_count <= err_cnt;
    points_pending <= expected_points.size();
  end

endmodule

// ----- tb/tb_depth_pixel_to_world_point.sv -----
`timescale 1ns / 1ps
// Top of the pixel-to-world bench: clock, reset, register writes and pixel stimulus.
// Depends on dpw_pkg, depth_pixel_to_world_point and dpw_point_checker.
module tb_depth_pixel_to_world_point;
  import dpw_pkg::*;

  localparam int PIXEL_TARGET = 950;
  localparam int SETTLE_CYCLES = 14;   // pipeline is 9 deep

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_data;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [47:0] cfg_data;
  int         mismatch_count;
  int         points_pending;
  logic       no_idle;
  int         pixels_sent;

  depth_pixel_to_world_point u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dpw_point_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .points_pending (points_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_pixel(input int u, input int v, input int d,
                                          input logic [23:0] bgr);
    in_item_t px;
    px.col       = 12'(u);
    px.row       = 12'(v);
    px.depth_raw = 16'(d);
    {px.blue_in, px.green_in, px.red_in} = bgr;
    return px;
  endfunction

  function automatic in_item_t rand_pixel();
    int r;
    int d;
    int u;
    int v;
    r = $urandom_range(0, 99);
    if (r < 8) d = 0;
    else if (r < 20) d = $urandom_range(1, 10);
    else if (r < 70) d = $urandom_range(300, 8000);
    else if (r < 90) d = $urandom_range(1, 65535);
    else d = $urandom_range(60000, 65535);
    if ($urandom_range(0, 1)) begin
      u = $urandom_range(0, 639);
      v = $urandom_range(0, 479);
    end else begin
      u = $urandom_range(0, 4095);
      v = $urandom_range(0, 4095);
    end
    return make_pixel(u, v, d, 24'($urandom));
  endfunction

  function automatic logic [15:0] near_q14(input int center, input int spread);
    return 16'(center + $urandom_range(0, 2 * spread) - spread);
  endfunction

  function automatic logic [15:0] rand_q14();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000;
      3: return 16'hc000;
      default: return 16'($urandom);
    endcase
  endfunction

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input cfg_reg_e idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_pixel(input in_item_t px);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    start   <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (busy);
    pixels_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending, wait out every pending point, then let dropped pixels flush
  task automatic drain_points();
    start <= 1'b0;
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // junk in bits 47:32 of 32-bit registers must be ignored
  task automatic write_word(input cfg_reg_e idx, input logic [31:0] val);
    write_reg(idx, {16'($urandom), val});
  endtask

  task automatic write_pose(input logic [47:0] r0, input logic [47:0] r1,
                            input logic [47:0] r2, input logic [31:0] tx,
                            input logic [31:0] ty, input logic [31:0] tz,
                            input logic [31:0] pp, input logic [47:0] fr);
    write_reg(REG_ROT_ROW0, r0);
    write_reg(REG_ROT_ROW1, r1);
    write_reg(REG_ROT_ROW2, r2);
    write_word(REG_TRANS_X, tx);
    write_word(REG_TRANS_Y, ty);
    write_word(REG_TRANS_Z, tz);
    write_word(REG_PRINC_PT, pp);
    write_reg(REG_FOCAL_RCP, fr);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_pose(input int kind);
    logic [31:0] t_m;
    if (kind == 0) begin
      // camera-like: near identity, a few metres of offset, sane intrinsics
      t_m = 32'($urandom_range(0, 20 << 16) - (10 << 16));
      write_pose({near_q14(16384, 2000), near_q14(0, 2000), near_q14(0, 2000)},
                 {near_q14(0, 2000), near_q14(16384, 2000), near_q14(0, 2000)},
                 {near_q14(0, 2000), near_q14(0, 2000), near_q14(16384, 2000)},
                 t_m, 32'($urandom_range(0, 20 << 16) - (10 << 16)),
                 32'($urandom_range(0, 20 << 16) - (10 << 16)),
                 {16'($urandom_range(3200, 6400)), 16'($urandom_range(2400, 4800))},
                 {24'($urandom_range(20000, 60000)), 24'($urandom_range(20000, 60000))});
    end else if (kind == 1) begin
      write_pose({$urandom, 16'($urandom)}, {$urandom, 16'($urandom)},
                 {$urandom, 16'($urandom)}, $urandom, $urandom, $urandom,
                 $urandom, {$urandom, 16'($urandom)});
    end else begin
      write_pose({rand_q14(), rand_q14(), rand_q14()}, {rand_q14(), rand_q14(), rand_q14()},
                 {rand_q14(), rand_q14(), rand_q14()},
                 $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000,
                 $urandom_range(0, 1) ? 32'h0 : $urandom, $urandom,
                 $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0,
                 $urandom_range(0, 1) ? 48'hffff_ffff_ffff : {$urandom, 16'($urandom)});
    end
  endtask

  initial begin
    int ph;
    int goal;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    no_idle   = 1'b0;
    pixels_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset pose: corners, no-measurement pixels, colour extremes
    send_pixel(make_pixel(0, 0, 0, 24'hffffff));
    send_pixel(make_pixel(0, 0, 1, 24'h000000));
    send_pixel(make_pixel(4095, 4095, 65535, 24'hff00ff));
    send_pixel(make_pixel(0, 4095, 65535, 24'haa55aa));
    send_pixel(make_pixel(4095, 0, 1000, 24'h55aa55));
    send_pixel(make_pixel(325, 253, 1000, 24'h123456));
    send_pixel(make_pixel(4095, 4095, 0, 24'h000000));
    drain_points();

    // extreme pose, drives x and y into saturation both ways and z into positive saturation
    write_pose({16'h8000, 16'h7fff, 16'h8000}, {16'h7fff, 16'h8000, 16'h7fff},
               {16'h8000, 16'h8000, 16'h8000}, 32'h7fff_ffff, 32'h8000_0000,
               32'h0001_0000, 32'hffff_ffff, 48'hffff_ffff_ffff);
    send_pixel(make_pixel(0, 0, 65535, 24'hffffff));
    send_pixel(make_pixel(4095, 4095, 65535, 24'h000000));
    send_pixel(make_pixel(0, 4095, 1, 24'h0f0f0f));
    send_pixel(make_pixel(4095, 0, 65535, 24'hf0f0f0));
    send_pixel(make_pixel(2048, 2048, 32768, 24'h808080));
    drain_points();

    // all-zero pose: only translation (zero) survives
    write_pose('0, '0, '0, '0, '0, '0, '0, '0);
    send_pixel(make_pixel(4095, 4095, 65535, 24'h7f7f7f));
    send_pixel(make_pixel(0, 0, 1, 24'hfefefe));
    drain_points();

    ph = 0;
    while (pixels_sent < PIXEL_TARGET) begin
      random_pose(ph % 3);
      no_idle = (ph % 4 == 1);
      goal = pixels_sent + $urandom_range(60, 160);
      while (pixels_sent < goal && pixels_sent < PIXEL_TARGET)
        send_pixel(rand_pixel());
      drain_points();
      ph++;
    end

    if (mismatch_count == 0 && points_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
